FILE: src/ljpf_pkg.sv
// Shared widths, register codes, reset values and side-band types for the
// Lennard-Jones pair force pipeline. No dependencies.
`default_nettype none

package ljpf_pkg;

  // Field widths
  localparam int POS_W   = 24;
  localparam int CFG_W   = 24;
  localparam int OUT_W   = 32;
  localparam int CIDX_W  = 4;

  // Datapath widths
  localparam int DIFF_W  = 26;   // signed displacement
  localparam int ABS_W   = 25;   // displacement magnitude
  localparam int SQ_W    = 50;   // one squared axis
  localparam int R2_W    = 51;   // squared distance
  localparam int DEN_W   = 40;   // squared distance inside the cutoff
  localparam int AXC_W   = 20;   // axis magnitude inside the cutoff
  localparam int QUO_W   = 56;   // divider numerator / quotient
  localparam int MUL_W   = 64;   // saturating Q.16 product
  localparam int FRAC_W  = 16;

  // Side-band delays, matched to the datapath stage count
  localparam int DIV_LAT   = QUO_W;
  localparam int MUL_LAT   = 2;
  localparam int FLAG_DLY  = 68;
  localparam int SIGN_DLY  = 7;
  localparam int Q_DLY     = 10;
  localparam int PIPE_LAT  = 73;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_BOX    = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_CUTOFF = 4'd1;
  localparam logic [CIDX_W-1:0] CFG_SIGMA  = 4'd2;
  localparam logic [CIDX_W-1:0] CFG_EPS    = 4'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] BOX_RST    = 24'd655360;
  localparam logic [CFG_W-1:0] CUTOFF_RST = 24'd409600;
  localparam logic [CFG_W-1:0] SIGMA_RST  = 24'd65536;
  localparam logic [CFG_W-1:0] EPS_RST    = 24'd65536;

  // Q.16 constants
  localparam logic [MUL_W-1:0] HALF_Q = 64'd32768;
  localparam logic [MUL_W-1:0] ONE_Q  = 64'd65536;

  // Per-pair flags carried alongside the datapath
  typedef struct packed {
    logic near;
    logic zero;
    logic xneg;
    logic yneg;
  } flags_t;

  typedef struct packed {
    logic gneg;
    logic eneg;
  } signs_t;

endpackage

`default_nettype wire

FILE: src/lennard_jones_pair_force.sv
// Lennard-Jones pair force top level: config registers, geometry stages,
// dividers, saturating multiply chain and output stage. Uses ljpf_pkg,
// ljpf_div, ljpf_mulq and ljpf_delay.
//
// One particle pair enters per clock, and the pipeline's depth is set mostly
// by the 56-stage bit-per-stage dividers that form
// sigma^2/r^2 and |r|/r^2, followed by five two-stage 64-bit multiplies. The
// whole pipeline advances together and holds while a finished beat waits on
// out_stall, so a new pair is taken every cycle the output drains. The
// config port is always ready; write registers only while the pipe is empty.
`default_nettype none

module lennard_jones_pair_force
  import ljpf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // pair input
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic        [POS_W-1:0]  first_x,
  input  wire logic        [POS_W-1:0]  first_y,
  input  wire logic        [POS_W-1:0]  second_x,
  input  wire logic        [POS_W-1:0]  second_y,
  // result output
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed      [OUT_W-1:0]  push_x,
  output logic signed      [OUT_W-1:0]  push_y,
  output logic signed      [OUT_W-1:0]  pair_energy,
  output logic                          within_cutoff,
  output logic                          clipped,
  // config writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic        [CIDX_W-1:0] cfg_index,
  input  wire logic        [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] box_length, cutoff_squared, sigma_squared, well_depth;
  logic [PIPE_LAT-1:0] vld;
  logic en;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length     <= BOX_RST;
      cutoff_squared <= CUTOFF_RST;
      sigma_squared  <= SIGMA_RST;
      well_depth     <= EPS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BOX:    box_length     <= cfg_data;
        CFG_CUTOFF: cutoff_squared <= cfg_data;
        CFG_SIGMA:  sigma_squared  <= cfg_data;
        CFG_EPS:    well_depth     <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: hold only when the output beat is stuck
  assign en        = ~vld[PIPE_LAT-1] | ~out_stall;
  assign in_stall  = ~en;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // stage 1: raw displacement
  logic signed [DIFF_W-1:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= $signed({2'b00, second_x}) - $signed({2'b00, first_x});
      dy1 <= $signed({2'b00, second_y}) - $signed({2'b00, first_y});
    end
  end

  // stage 2: minimum image, magnitude and sign of r = -d
  function automatic logic signed [DIFF_W:0] fold(input logic signed [DIFF_W-1:0] d,
                                                 input logic [CFG_W-1:0] len);
    logic signed [DIFF_W:0] dd, twod, l;
    dd   = {d[DIFF_W-1], d};
    twod = {d, 1'b0};
    l    = $signed({3'b000, len});
    if (twod > l) begin
      dd = dd - l;
    end else if (twod < -l) begin
      dd = dd + l;
    end
    return dd;
  endfunction

  logic signed [DIFF_W:0] fx, fy;
  logic [DIFF_W:0] nfx, nfy;
  logic [ABS_W-1:0] ax2, ay2;
  logic xneg2, yneg2;

  always_comb begin
    fx  = fold(dx1, box_length);
    fy  = fold(dy1, box_length);
    nfx = -fx;
    nfy = -fy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2   <= fx[DIFF_W] ? nfx[ABS_W-1:0] : fx[ABS_W-1:0];
      ay2   <= fy[DIFF_W] ? nfy[ABS_W-1:0] : fy[ABS_W-1:0];
      xneg2 <= fx > 0;
      yneg2 <= fy > 0;
    end
  end

  // stage 3: squares
  logic [SQ_W-1:0] sqx3, sqy3;
  logic [ABS_W-1:0] ax3, ay3;
  logic xneg3, yneg3;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx3  <= ax2 * ax2;
      sqy3  <= ay2 * ay2;
      ax3   <= ax2;
      ay3   <= ay2;
      xneg3 <= xneg2;
      yneg3 <= yneg2;
    end
  end

  // stage 4: squared distance and cutoff test
  logic [R2_W-1:0] r2;
  logic [DEN_W-1:0] den4;
  logic [AXC_W-1:0] ax4, ay4;
  flags_t flags4;

  assign r2 = {1'b0, sqx3} + {1'b0, sqy3};

  always_ff @(posedge clk) begin
    if (en) begin
      den4        <= r2[DEN_W-1:0];
      ax4         <= ax3[AXC_W-1:0];
      ay4         <= ay3[AXC_W-1:0];
      flags4.near <= r2 < {{(R2_W-CFG_W-FRAC_W){1'b0}}, cutoff_squared, {FRAC_W{1'b0}}};
      flags4.zero <= r2 == '0;
      flags4.xneg <= xneg3;
      flags4.yneg <= yneg3;
    end
  end

  // dividers: s = sigma^2/r^2, q = |r|/r^2 per axis
  logic [QUO_W-1:0] s_q, qx_q, qy_q;

  ljpf_div #(.NW(QUO_W), .DW(DEN_W)) u_div_s (
    .clk(clk), .en(en),
    .num({sigma_squared, {(QUO_W-CFG_W){1'b0}}}),
    .den(den4), .quo(s_q)
  );

  ljpf_div #(.NW(QUO_W), .DW(DEN_W)) u_div_x (
    .clk(clk), .en(en),
    .num({{(QUO_W-AXC_W-2*FRAC_W){1'b0}}, ax4, {(2*FRAC_W){1'b0}}}),
    .den(den4), .quo(qx_q)
  );

  ljpf_div #(.NW(QUO_W), .DW(DEN_W)) u_div_y (
    .clk(clk), .en(en),
    .num({{(QUO_W-AXC_W-2*FRAC_W){1'b0}}, ay4, {(2*FRAC_W){1'b0}}}),
    .den(den4), .quo(qy_q)
  );

  // s^2, then s^3
  logic [MUL_W-1:0] s_ext, s2, s3;
  logic [QUO_W-1:0] s_d;

  assign s_ext = {{(MUL_W-QUO_W){1'b0}}, s_q};

  ljpf_mulq u_mul_s2 (.clk(clk), .en(en), .a(s_ext), .b(s_ext), .p(s2));

  ljpf_delay #(.W(QUO_W), .DEPTH(MUL_LAT)) u_dly_s (
    .clk(clk), .en(en), .d(s_q), .q(s_d)
  );

  ljpf_mulq u_mul_s3 (
    .clk(clk), .en(en), .a(s2), .b({{(MUL_W-QUO_W){1'b0}}, s_d}), .p(s3)
  );

  // offsets from 0.5 and 1.0 with their signs
  logic [MUL_W-1:0] s3_h, hf_h, he_h;
  signs_t signs_h, signs_d;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_h         <= s3;
      signs_h.gneg <= s3 < HALF_Q;
      signs_h.eneg <= s3 < ONE_Q;
      hf_h         <= (s3 < HALF_Q) ? HALF_Q - s3 : s3 - HALF_Q;
      he_h         <= (s3 < ONE_Q) ? ONE_Q - s3 : s3 - ONE_Q;
    end
  end

  // s3 times offsets
  logic [MUL_W-1:0] tf, te;

  ljpf_mulq u_mul_tf (.clk(clk), .en(en), .a(s3_h), .b(hf_h), .p(tf));
  ljpf_mulq u_mul_te (.clk(clk), .en(en), .a(s3_h), .b(he_h), .p(te));

  // scale by 48 and 4, clamped
  logic [MUL_W+5:0] w48;
  logic [MUL_W-1:0] uf, ue;

  assign w48 = ({6'b0, tf} << 5) + ({6'b0, tf} << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      uf <= (|w48[MUL_W+5:MUL_W]) ? '1 : w48[MUL_W-1:0];
      ue <= (|te[MUL_W-1:MUL_W-2]) ? '1 : {te[MUL_W-3:0], 2'b00};
    end
  end

  // times well depth
  logic [MUL_W-1:0] eps_ext, g, e, e_d;

  assign eps_ext = {{(MUL_W-CFG_W){1'b0}}, well_depth};

  ljpf_mulq u_mul_g (.clk(clk), .en(en), .a(uf), .b(eps_ext), .p(g));
  ljpf_mulq u_mul_e (.clk(clk), .en(en), .a(ue), .b(eps_ext), .p(e));

  // force components
  logic [QUO_W-1:0] qx_d, qy_d;
  logic [MUL_W-1:0] px, py;

  ljpf_delay #(.W(QUO_W), .DEPTH(Q_DLY)) u_dly_qx (
    .clk(clk), .en(en), .d(qx_q), .q(qx_d)
  );

  ljpf_delay #(.W(QUO_W), .DEPTH(Q_DLY)) u_dly_qy (
    .clk(clk), .en(en), .d(qy_q), .q(qy_d)
  );

  ljpf_mulq u_mul_px (
    .clk(clk), .en(en), .a(g), .b({{(MUL_W-QUO_W){1'b0}}, qx_d}), .p(px)
  );

  ljpf_mulq u_mul_py (
    .clk(clk), .en(en), .a(g), .b({{(MUL_W-QUO_W){1'b0}}, qy_d}), .p(py)
  );

  ljpf_delay #(.W(MUL_W), .DEPTH(MUL_LAT)) u_dly_e (
    .clk(clk), .en(en), .d(e), .q(e_d)
  );

  // side-band alignment
  flags_t flags_d;

  ljpf_delay #(.W($bits(flags_t)), .DEPTH(FLAG_DLY)) u_dly_flags (
    .clk(clk), .en(en), .d(flags4), .q(flags_d)
  );

  ljpf_delay #(.W($bits(signs_t)), .DEPTH(SIGN_DLY)) u_dly_signs (
    .clk(clk), .en(en), .d(signs_h), .q(signs_d)
  );

  // output stage: sign, saturate, special cases
  localparam logic [MUL_W-1:0] POS_MAX = 64'h7FFF_FFFF;
  localparam logic [MUL_W-1:0] NEG_MAX = 64'h8000_0000;

  function automatic logic [OUT_W:0] to_out(input logic [MUL_W-1:0] mag, input logic neg);
    logic [OUT_W-1:0] negv;
    negv = -mag[OUT_W-1:0];
    if (!neg) begin
      return (mag > POS_MAX) ? {1'b1, POS_MAX[OUT_W-1:0]} : {1'b0, mag[OUT_W-1:0]};
    end
    return (mag > NEG_MAX) ? {1'b1, NEG_MAX[OUT_W-1:0]} : {1'b0, negv};
  endfunction

  logic [OUT_W:0] ox, oy, oe;

  always_comb begin
    ox = to_out(px, signs_d.gneg ^ flags_d.xneg);
    oy = to_out(py, signs_d.gneg ^ flags_d.yneg);
    oe = to_out(e_d, signs_d.eneg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (!flags_d.near) begin
        push_x        <= '0;
        push_y        <= '0;
        pair_energy   <= '0;
        within_cutoff <= 1'b0;
        clipped       <= 1'b0;
      end else if (flags_d.zero) begin
        push_x        <= '0;
        push_y        <= '0;
        pair_energy   <= POS_MAX[OUT_W-1:0];
        within_cutoff <= 1'b1;
        clipped       <= 1'b1;
      end else begin
        push_x        <= ox[OUT_W-1:0];
        push_y        <= oy[OUT_W-1:0];
        pair_energy   <= oe[OUT_W-1:0];
        within_cutoff <= 1'b1;
        clipped       <= ox[OUT_W] | oy[OUT_W] | oe[OUT_W];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/ljpf_delay.sv
// Enabled delay line for side-band data that rides along the pipeline.
// No dependencies.
`default_nettype none

module ljpf_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  // shift on enable
  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        taps[k] <= (k == 0) ? d : taps[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

`default_nettype wire

FILE: src/ljpf_div.sv
// Pipelined restoring divider, one quotient bit per stage, floor(num / den).
// No dependencies.
`default_nettype none

module ljpf_div #(
  parameter int NW = 56,
  parameter int DW = 40
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo
);

  logic [DW-1:0] rem_r [NW-1];
  logic [DW-1:0] den_r [NW-1];
  logic [NW-1:0] num_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [NW-1:0] num_i;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign den_i = den;
      assign num_i = num;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign num_i = num_r[k-1];
    end

    // trial subtract of the next numerator bit
    assign trial = {rem_i, num_i[NW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_i[NW-2:0], ~diff[DW+1]};
      end
    end

    if (k < NW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
          den_r[k] <= den_i;
        end
      end
    end
  end

  assign quo = num_r[NW-1];

endmodule

`default_nettype wire

FILE: src/ljpf_mulq.sv
// Two-stage Q.16 multiply, floor(a*b / 2^16) clamped to all ones.
// Depends on ljpf_pkg.
`default_nettype none

module ljpf_mulq
  import ljpf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [MUL_W-1:0] a,
  input  wire logic [MUL_W-1:0] b,
  output logic      [MUL_W-1:0] p
);

  localparam int H = MUL_W / 2;

  logic [MUL_W-1:0]   pll, plh, phl, phh;
  logic [MUL_W:0]     mid;
  logic [2*MUL_W-1:0] full;

  // stage A: four 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pll <= a[H-1:0] * b[H-1:0];
      plh <= a[H-1:0] * b[MUL_W-1:H];
      phl <= a[MUL_W-1:H] * b[H-1:0];
      phh <= a[MUL_W-1:H] * b[MUL_W-1:H];
    end
  end

  // stage B: sum, scale and clamp
  always_comb begin
    mid  = {1'b0, plh} + {1'b0, phl};
    full = {phh, pll} + {{(H-1){1'b0}}, mid, {H{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (|full[2*MUL_W-1:MUL_W+FRAC_W]) ? '1 : full[MUL_W+FRAC_W-1:FRAC_W];
    end
  end

endmodule

`default_nettype wire
